### sv/bcsl_pkg.sv
// ---------------------------------------------------------------------------
// Banked compacting slot list: shared package
// Sizes, field layout, result codes and the command and status groups that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package bcsl_pkg;

  // Block sizes.
  localparam int NUM_BANKS = 9;
  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 22;
  localparam int TAG_BITS  = 8;

  // Fixed field widths of the words on the ports.
  localparam int MODE_FW   = 1;
  localparam int BANK_FW   = 4;
  localparam int KEY_FW    = 22;
  localparam int TAG_FW    = 8;
  localparam int STATUS_FW = 2;
  localparam int COUNT_FW  = 5;

  // Packed input tdata: bank, key, tag from bit 0 up, padded to bytes.
  localparam int S_DATA_BITS = BANK_FW + KEY_FW + TAG_FW;
  localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int BANK_LSB    = 0;
  localparam int KEY_LSB     = BANK_FW;
  localparam int TAG_LSB     = BANK_FW + KEY_FW;

  // Packed output tdata: count, padded to a byte.
  localparam int M_TDATA_W = ((COUNT_FW + 7) / 8) * 8;

  // Derived internal widths.
  localparam int DEPTH     = NUM_BANKS * ENTRIES;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BANK_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int SLOT_W    = KEY_BITS + TAG_BITS;
  localparam int KEY_EXT_W = (KEY_BITS > KEY_FW) ? KEY_BITS : KEY_FW;
  localparam int CNT_EXT_W = (CNT_W > COUNT_FW) ? CNT_W : COUNT_FW;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [STATUS_FW-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_REMOVED  = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic    load_req;   // capture the accepted request
    logic    wr_insert;  // write the request at the tail slot
    logic    rd_scan;    // read the slot at the scan index
    logic    rd_next;    // read the slot above the scan index
    logic    wr_shift;   // write the read slot one place down
    logic    idx_clr;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;   // place a result in the output register
    status_e status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mode;
    logic bank_ok;
    logic key_zero;
    logic full;
    logic cnt_zero;
    logic match;
    logic scan_last;
    logic shift_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### sv/banked_compacting_slot_list_unit.sv
// ---------------------------------------------------------------------------
// Banked compacting slot list unit
// Nine ordered lists of sixteen key and tag slots, kept packed at the front.
// Inserts append at the tail; removes find the first matching key and close
// the gap by shifting the later slots down.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  tuser              tdata (lowest bit first)
//  --------  ---  -----------------  ---------------------------------------
//  s_axis    in   mode (1)           bank (4), key (22), tag (8), pad to 40
//  m_axis    out  status (2)         count (5), pad to 8
//
//  Each request word gives exactly one result word.
//  An insert, a rejected request or a remove of an empty key is settled in
//  the decision step; a remove in a bank holding entries works slot by slot,
//  since every scan compare and every shift step goes through the single
//  port of the slot memory with a registered read.
//  A new word is taken only while the controller is idle; a finished result
//  waits in the output register, so a stalled output leaves at most two
//  results in the unit: one in that register and one held by the controller.
//  Reset clears the bank counts; slots above a bank's count are never read,
//  so the slot memory needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module banked_compacting_slot_list_unit
  import bcsl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Request words.
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,   // bank, key, tag, zero pad
  input  wire logic [MODE_FW-1:0]   s_axis_tuser_i,   // mode
  // Result words.
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,   // count, zero pad
  output logic [STATUS_FW-1:0]      m_axis_tuser_o    // status
);

  cmd_t cmd;
  sts_t sts;

  // The controller owns the sequencing and the request handshake.
  bcsl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath holds the request, counts, slot memory and result register.
  bcsl_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_mode_i   (s_axis_tuser_i[0]),
    .s_data_i   (s_axis_tdata_i),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .m_status_o (m_axis_tuser_o),
    .m_data_o   (m_axis_tdata_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

### sv/bcsl_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bcsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

### sv/bcsl_datapath.sv
// ---------------------------------------------------------------------------
// Banked compacting slot list: datapath
// Request registers, per-bank fill counts, slot memory, scan index and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bcsl_datapath
  import bcsl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_mode_i,
  input  wire logic [S_TDATA_W-1:0] s_data_i,
  input  wire logic                 m_ready_i,
  output logic                      m_valid_o,
  output logic [STATUS_FW-1:0]      m_status_o,
  output logic [M_TDATA_W-1:0]      m_data_o,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o
);

  logic                 req_mode_q;
  logic [BANK_FW-1:0]   req_bank_q;
  logic [KEY_BITS-1:0]  req_key_q;
  logic [TAG_BITS-1:0]  req_tag_q;
  logic [KEY_EXT_W-1:0] key_ext;

  logic [CNT_W-1:0]     counts_q [NUM_BANKS];
  logic [IDX_W-1:0]     idx_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [COUNT_FW-1:0]  out_count_q;

  logic                 bank_ok;
  logic [BANK_W-1:0]    bank_idx;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     idx_plus;
  logic [ADDR_W-1:0]    base;
  logic [ADDR_W-1:0]    ram_addr;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_wdata;
  logic [SLOT_W-1:0]    ram_rdata;
  logic [CNT_EXT_W-1:0] cnt_ext;

  // Keys are taken in their low KEY_BITS bits.
  assign key_ext = KEY_EXT_W'(s_data_i[KEY_LSB +: KEY_FW]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_mode_q <= s_mode_i;
      req_bank_q <= s_data_i[BANK_LSB +: BANK_FW];
      req_key_q  <= key_ext[KEY_BITS-1:0];
      req_tag_q  <= s_data_i[TAG_LSB +: TAG_FW];
    end
  end

  assign bank_ok  = ({1'b0, req_bank_q} < (BANK_FW + 1)'(NUM_BANKS));
  assign bank_idx = req_bank_q[BANK_W-1:0];
  assign cnt      = bank_ok ? counts_q[bank_idx] : '0;
  assign idx_plus = CNT_W'(idx_q) + CNT_W'(1);
  assign base     = ADDR_W'(ADDR_W'(bank_idx) * ADDR_W'(ENTRIES));

  always_comb begin
    ram_addr  = base + ADDR_W'(idx_q);
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if (cmd_i.wr_insert) begin
      ram_addr  = base + ADDR_W'(cnt);
      ram_we    = 1'b1;
      ram_wdata = {req_key_q, req_tag_q};
    end else if (cmd_i.rd_next) begin
      ram_addr  = base + ADDR_W'(idx_plus);
    end else if (cmd_i.wr_shift) begin
      ram_we    = 1'b1;
    end
  end

  bcsl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        counts_q[b] <= '0;
      end
      idx_q <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        counts_q[bank_idx] <= cnt + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        counts_q[bank_idx] <= cnt - CNT_W'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // Output register: a result waits here while the next request is taken.
  assign cnt_ext = CNT_EXT_W'(cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.status;
      out_count_q  <= cnt_ext[COUNT_FW-1:0];
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_data_o   = M_TDATA_W'(out_count_q);

  always_comb begin
    sts_o            = '0;
    sts_o.mode       = req_mode_q;
    sts_o.bank_ok    = bank_ok;
    sts_o.key_zero   = (req_key_q == '0);
    sts_o.full       = (cnt >= CNT_W'(ENTRIES));
    sts_o.cnt_zero   = (cnt == '0);
    sts_o.match      = (ram_rdata[SLOT_W-1:TAG_BITS] == req_key_q);
    sts_o.scan_last  = (idx_plus == cnt);
    sts_o.shift_done = (idx_plus >= cnt);
    sts_o.out_busy   = out_valid_q && !m_ready_i;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_ok |-> (cnt <= CNT_W'(ENTRIES)))
    else $error("bank count above capacity");

  a_insert_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_insert |-> (bank_ok && (cnt < CNT_W'(ENTRIES)) && (req_key_q != '0)))
    else $error("insert write without room or with empty key");

  a_out_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !m_ready_i))
    else $error("result overwrote a word not yet taken");

endmodule

`default_nettype wire

### sv/bcsl_ctrl.sv
// ---------------------------------------------------------------------------
// Banked compacting slot list: controller
// Sequences one request: decide, scan for the key, shift the tail down and
// hand the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bcsl_ctrl
  import bcsl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  output logic      s_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DECIDE   = 7'b0000010,
    ST_SCAN_RD  = 7'b0000100,
    ST_SCAN_CMP = 7'b0001000,
    ST_SHIFT_RD = 7'b0010000,
    ST_SHIFT_WR = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_DONE;
        if (!sts_i.bank_ok) begin
          res_d = (sts_i.mode == MODE_INSERT) ? STAT_REJECTED : STAT_NOTFOUND;
        end else if (sts_i.mode == MODE_INSERT) begin
          if (sts_i.key_zero || sts_i.full) begin
            res_d = STAT_REJECTED;
          end else begin
            cmd_o.wr_insert = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
            res_d           = STAT_INSERTED;
          end
        end else if (sts_i.key_zero || sts_i.cnt_zero) begin
          res_d = STAT_NOTFOUND;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts_i.match) begin
          state_d = ST_SHIFT_RD;
        end else if (sts_i.scan_last) begin
          res_d   = STAT_NOTFOUND;
          state_d = ST_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (sts_i.shift_done) begin
          cmd_o.cnt_dec = 1'b1;
          res_d         = STAT_REMOVED;
          state_d       = ST_DONE;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = ST_SHIFT_RD;
      end
      ST_DONE: begin
        cmd_o.status = res_q;
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  a_accept_decide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == ST_DECIDE))
    else $error("accepted word did not move to the decision step");

endmodule

`default_nettype wire

### test/banked_compacting_slot_list_unit_tb.sv
// ---------------------------------------------------------------------------
// Banked compacting slot list unit: self-checking testbench
// Drives insert and remove request words into the unit and keeps a shadow
// copy of every bank's slots. Each request word is predicted as it is
// accepted, and every result word is checked in order against that
// prediction, under random input gaps and output stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module banked_compacting_slot_list_unit_tb;

  import bcsl_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;    // longer than a remove in a full bank
  localparam int HOLD_CYCLES  = 300;   // one long output stall
  localparam int KEY_POOL     = 12;    // small keys give many duplicates

  // How the result side paces its tready.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_style_e;

  typedef struct packed {
    status_e             status;
    logic [COUNT_FW-1:0] count;
  } list_result_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 s_tvalid  = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [MODE_FW-1:0]   s_tuser   = '0;
  logic                 m_tready  = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_FW-1:0] m_axis_tuser_o;

  // Shadow of the slot lists, updated in acceptance order.
  logic [KEY_BITS-1:0] slot_key [NUM_BANKS][ENTRIES];
  logic [TAG_BITS-1:0] slot_tag [NUM_BANKS][ENTRIES];
  int unsigned         bank_fill [NUM_BANKS];
  bit                  bank_draining [NUM_BANKS];

  // Results owed by the unit, oldest first.
  list_result_t results_due[$];

  rx_style_e rx_style    = RX_ALWAYS;
  int        hold_cycles = 0;
  bit        gaps_on     = 1'b0;
  bit        offering    = 1'b0;
  int        burst_left  = 4;
  int        cycle_count = 0;
  int        mismatches  = 0;
  int        words_sent  = 0;
  int        full_rejects = 0;
  int        wide_banks  = 0;
  int        status_seen [4];

  banked_compacting_slot_list_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // bank, key, tag, zero pad
    .s_axis_tuser_i  (s_tuser),   // mode
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // count, zero pad
    .m_axis_tuser_o  (m_axis_tuser_o)    // status
  );

  always #5 clk_i = ~clk_i;

  // Runaway guard: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, results_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Applies one request to the shadow lists and returns the result the unit
  // must give for it. An out-of-range bank touches nothing and reports 0.
  function automatic list_result_t slot_list_apply(
    input logic                mode,
    input logic [BANK_FW-1:0]  bank,
    input logic [KEY_FW-1:0]   key_in,
    input logic [TAG_FW-1:0]   tag
  );
    list_result_t        res;
    logic [KEY_BITS-1:0] key;
    int unsigned         b;
    int unsigned         n;
    int                  hit;
    key       = key_in[KEY_BITS-1:0];
    res.count = '0;
    hit       = -1;
    if (bank >= NUM_BANKS) begin
      wide_banks++;
      res.status = (mode == MODE_INSERT) ? STAT_REJECTED : STAT_NOTFOUND;
      return res;
    end
    b = 32'(bank);
    n = bank_fill[b];
    if (mode == MODE_INSERT) begin
      if (key == '0 || n >= ENTRIES) begin
        if (n >= ENTRIES) full_rejects++;
        res.status = STAT_REJECTED;
      end else begin
        slot_key[b][n] = key;
        slot_tag[b][n] = tag;
        n++;
        res.status = STAT_INSERTED;
      end
    end else begin
      // Scan from the top so the lowest matching slot wins.
      if (key != '0) begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (slot_key[b][i] == key) hit = i;
        end
      end
      if (hit < 0) begin
        res.status = STAT_NOTFOUND;
      end else begin
        for (int j = hit; j < ENTRIES - 1; j++) begin
          slot_key[b][j] = slot_key[b][j+1];
          slot_tag[b][j] = slot_tag[b][j+1];
        end
        slot_key[b][ENTRIES-1] = '0;
        slot_tag[b][ENTRIES-1] = '0;
        if (n > 0) n--;
        res.status = STAT_REMOVED;
      end
    end
    bank_fill[b] = n;
    res.count    = n[COUNT_FW-1:0];
    return res;
  endfunction

  // Offers one request word and returns at the edge where it is taken. The
  // valid stays high into the next call unless a gap starts here.
  task automatic send_request(
    input logic               mode,
    input logic [BANK_FW-1:0] bank,
    input logic [KEY_FW-1:0]  key,
    input logic [TAG_FW-1:0]  tag
  );
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[BANK_LSB +: BANK_FW] = bank;
    word[KEY_LSB +: KEY_FW]   = key;
    word[TAG_LSB +: TAG_FW]   = tag;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= mode;
    offering  = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    results_due.push_back(slot_list_apply(mode, bank, key, tag));
    words_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_tvalid <= 1'b0;
        offering  = 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  task automatic stop_sending;
    if (offering) begin
      s_tvalid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  task automatic wait_for_results;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // Builds one random request. Most requests aim at a hot bank that is
  // walked between empty and full, and most removes name a key that is
  // really stored there, so the shift path sees every depth.
  task automatic random_request(input int hot_bank);
    logic               mode;
    logic [BANK_FW-1:0] bank;
    logic [KEY_FW-1:0]  key;
    logic [TAG_FW-1:0]  tag;
    int                 pick;
    int unsigned        b;
    pick = $urandom_range(0, 99);
    if (pick < 4) bank = BANK_FW'($urandom_range(NUM_BANKS, (1 << BANK_FW) - 1));
    else if (pick < 60) bank = BANK_FW'(hot_bank);
    else bank = BANK_FW'($urandom_range(0, NUM_BANKS - 1));
    tag  = TAG_FW'($urandom);
    b    = 32'(bank);
    mode = ($urandom_range(0, 99) < 50) ? MODE_INSERT : MODE_REMOVE;
    if (bank < NUM_BANKS) begin
      if (bank_fill[b] == ENTRIES) bank_draining[b] = 1'b1;
      else if (bank_fill[b] == 0) bank_draining[b] = 1'b0;
      if ($urandom_range(0, 99) < 72)
        mode = bank_draining[b] ? MODE_REMOVE : MODE_INSERT;
      else
        mode = bank_draining[b] ? MODE_INSERT : MODE_REMOVE;
    end
    pick = $urandom_range(0, 99);
    if (mode == MODE_INSERT) begin
      if (pick < 5) key = '0;
      else if (pick < 45) key = KEY_FW'($urandom_range(1, KEY_POOL));
      else key = KEY_FW'($urandom);
    end else begin
      if (pick < 70 && bank < NUM_BANKS && bank_fill[b] != 0)
        key = slot_key[b][$urandom_range(0, bank_fill[b] - 1)];
      else if (pick < 80) key = KEY_FW'($urandom_range(1, KEY_POOL));
      else if (pick < 85) key = '0;
      else key = KEY_FW'($urandom);
    end
    send_request(mode, bank, key, tag);
  endtask

  // Result side pacing. The long hold is counted down here, independent of
  // the sender, so the unit backs up and drops its tready.
  always @(posedge clk_i) begin : rx_pacing
    logic ready_next;
    case (rx_style)
      RX_ALWAYS:  ready_next = 1'b1;
      RX_RANDOM:  ready_next = ($urandom_range(0, 3) != 0);
      RX_PATTERN: ready_next = ((cycle_count % 11) < 6) || ((cycle_count % 11) == 8);
      default:    ready_next = ($urandom_range(0, 9) < 3);
    endcase
    if (hold_cycles > 0) begin
      ready_next = 1'b0;
      hold_cycles--;
    end
    m_tready <= ready_next;
  end

  // Every taken result word is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    list_result_t due;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: status %0d count %0d",
                   m_axis_tuser_o, m_axis_tdata_o[COUNT_FW-1:0]);
      end else begin
        due = results_due.pop_front();
        status_seen[due.status]++;
        if (m_axis_tuser_o !== due.status ||
            m_axis_tdata_o[COUNT_FW-1:0] !== due.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at cycle %0d: status exp %s got %0d, count exp %0d got %0d",
                     cycle_count, due.status.name(), m_axis_tuser_o, due.count,
                     m_axis_tdata_o[COUNT_FW-1:0]);
        end
      end
    end
  end

  // Corners: widest key and tag, key zero on both operations, banks past
  // the last one, duplicate keys and a miss in an occupied bank.
  task automatic test_corner_cases;
    send_request(MODE_INSERT, 4'd0, {KEY_FW{1'b1}}, 8'hFF);
    send_request(MODE_INSERT, 4'd0, '0, 8'h12);
    send_request(MODE_REMOVE, 4'd0, '0, 8'h00);
    send_request(MODE_INSERT, 4'hF, 22'h000123, 8'h00);
    send_request(MODE_REMOVE, BANK_FW'(NUM_BANKS), {KEY_FW{1'b1}}, 8'hA5);
    send_request(MODE_INSERT, BANK_FW'(NUM_BANKS - 1), 22'd1, 8'h0F);
    send_request(MODE_INSERT, BANK_FW'(NUM_BANKS - 1), 22'd1, 8'hF0);
    send_request(MODE_REMOVE, BANK_FW'(NUM_BANKS - 1), 22'd1, 8'h00);
    send_request(MODE_REMOVE, BANK_FW'(NUM_BANKS - 1), 22'd5, 8'h00);
    send_request(MODE_REMOVE, 4'd0, {KEY_FW{1'b1}}, 8'h00);
  endtask

  // One bank filled to capacity, then one insert too many.
  task automatic test_full_bank;
    for (int i = 0; i <= ENTRIES; i++)
      send_request(MODE_INSERT, 4'd5, KEY_FW'(100 + i), i[TAG_FW-1:0]);
  endtask

  // Long random run in phases, each with its own hot bank, gap setting and
  // result pacing.
  task automatic test_random_traffic(input int n_items);
    int hot_bank;
    hot_bank = 5;
    for (int k = 0; k < n_items; k++) begin
      if (k % 250 == 0) begin
        rx_style = rx_style_e'((k / 250) % 4);
        gaps_on  = ((k / 250) % 3) != 1;
        hot_bank = $urandom_range(0, NUM_BANKS - 1);
      end
      random_request(hot_bank);
    end
    stop_sending();
    wait_for_results();
  endtask

  // The output holds off for a long stretch while words keep coming.
  task automatic test_output_backpressure;
    rx_style    = RX_ALWAYS;
    gaps_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (int k = 0; k < 40; k++) random_request(k % NUM_BANKS);
    stop_sending();
    wait_for_results();
  endtask

  initial begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_fill[b]     = 0;
      bank_draining[b] = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[b][i] = '0;
        slot_tag[b][i] = '0;
      end
    end
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_full_bank();
    stop_sending();
    wait_for_results();
    test_random_traffic(1450);
    test_output_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (results_due.size() != 0) begin
      mismatches += results_due.size();
      $display("%0d predicted results never arrived.", results_due.size());
    end
    $display("Covered %0d requests: %0d inserted, %0d rejected, %0d removed, %0d missed.",
             words_sent, status_seen[STAT_INSERTED], status_seen[STAT_REJECTED],
             status_seen[STAT_REMOVED], status_seen[STAT_NOTFOUND]);
    $display("Full-bank rejects %0d, out-of-range banks %0d, %0d mismatches in %0d cycles.",
             full_rejects, wide_banks, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
